/* hw/rtl/psh_pkg.sv */
package psh_pkg;

   // default sizing of the histogram store
   localparam int MAX_CLASSES_DEF = 16;
   localparam int MAX_BINS_DEF    = 64;
   localparam int SIZE_BITS_DEF   = 24;

   // field widths on the ports
   localparam int FUNC_W      = 1;
   localparam int CLASS_W     = 4;
   localparam int SIZE_W      = 24;
   localparam int SEL_W       = 6;
   localparam int BIN_IDX_W   = 6;
   localparam int CNT_W       = 32;
   localparam int BINS_CFG_W  = 7;
   localparam int WIDTH_CFG_W = 16;

   // packed word and register port widths, request and response words padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   // register reset values and counter ceiling
   localparam logic [BINS_CFG_W-1:0]  BINS_RESET  = 7'd50;
   localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 16'd100;
   localparam logic [CNT_W-1:0]       CNT_MAX     = '1;

   // register map
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BINS_IN_USE = 1'b0,
      CSR_BIN_WIDTH   = 1'b1
   } csr_reg_type;

   // request kinds
   typedef enum logic [FUNC_W-1:0] {
      FUNC_RECORD = 1'b0,
      FUNC_READ   = 1'b1
   } func_type;

   // control sequencer
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_UPDATE
   } state_type;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* hw/rtl/psh_ram.sv */
module psh_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/psh_div.sv */
module psh_div #(
   parameter int SIZE_BITS = psh_pkg::SIZE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [SIZE_BITS-1:0]               dividend,
   input  logic [psh_pkg::WIDTH_CFG_W-1:0]    divisor,
   output logic [SIZE_BITS-1:0]               quotient,
   output psh_pkg::div_stat_type              stat
);
   import psh_pkg::*;

   localparam int STEP_W = $clog2(SIZE_BITS + 1);
   localparam int DIV_W  = WIDTH_CFG_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [SIZE_BITS-1:0] quo_ff, quo_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W:0]       diff;
   logic                 fits;

   // one restoring step: bring down the next dividend bit and try a subtract
   // a zero divisor always fits, so the quotient saturates to all ones
   assign trial = {rem_ff, quo_ff[SIZE_BITS-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = (trial >= {1'b0, divisor});

   // step sequencing, one quotient bit a cycle, msb first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SIZE_BITS);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in  = {quo_ff[SIZE_BITS-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   // checks
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a preceding step");

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done together");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

/* hw/rtl/per_class_size_histogram_top.sv */
// record word: accepted in idle, then divided, read and updated; the next
//   word is taken only after the update, so one record is in work at a time
// read word: accepted in idle, then read and updated, one read in work at a time
// bit-serial divider, one quotient bit a cycle, sets the record rate if output is free
// reset: synchronous, active high; registers return to 50 bins, width 100, and
//   a pass over MAX_CLASSES * 2**clog2(MAX_BINS) entries (1024) zeroes both stores
module per_class_size_histogram_top #(
   parameter int MAX_CLASSES = psh_pkg::MAX_CLASSES_DEF,
   parameter int MAX_BINS    = psh_pkg::MAX_BINS_DEF,
   parameter int SIZE_BITS   = psh_pkg::SIZE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request word
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // class_id [3:0], sample_size [27:4], bin_select [33:28], zero pad
   input  logic [psh_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func [0]
   input  logic [psh_pkg::FUNC_W-1:0]        req_tuser,
   // response word
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // bin_index [5:0], bin_count [37:6], class_total [69:38], zero pad
   output logic [psh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // in_range [0]
   output logic [0:0]                        rsp_tuser,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [psh_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [psh_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import psh_pkg::*;

   localparam int BIN_W     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CLS_W     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int NB_W      = $clog2(MAX_BINS + 1);
   localparam int MEM_AW    = CLS_W + BIN_W;
   localparam int MEM_DEPTH = MAX_CLASSES * (2 ** BIN_W);
   localparam int RSP_PAD   = RSP_DATA_W - (BIN_IDX_W + 2 * CNT_W);

   state_type              state_ff, state_in;
   logic [BINS_CFG_W-1:0]  bins_ff;
   logic [WIDTH_CFG_W-1:0] width_ff;
   logic [MEM_AW-1:0]      clr_ff, clr_in;
   logic                   clr_last;

   func_type               func_ff, func_in;
   logic [CLS_W-1:0]       cls_ff, cls_in;
   logic [BIN_W-1:0]       bin_ff, bin_in;
   logic                   inr_ff, inr_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BIN_IDX_W-1:0]   rsp_bin_ff;
   logic [CNT_W-1:0]       rsp_count_ff;
   logic [CNT_W-1:0]       rsp_total_ff;
   logic                   rsp_inr_ff;

   func_type               req_func;
   logic [CLASS_W-1:0]     class_f;
   logic [SIZE_W-1:0]      size_f;
   logic [SEL_W-1:0]       sel_f;
   logic                   req_accept;
   logic [NB_W-1:0]        nb;
   logic [BIN_W-1:0]       bin_last;
   logic [CLS_W-1:0]       cls_fold;
   logic                   sel_ok;

   logic                   div_start;
   logic [SIZE_BITS-1:0]   quotient;
   div_stat_type           div_stat;
   logic [BIN_W-1:0]       bin_clamped;

   logic                   clearing;
   logic                   mem_rd_en;
   logic                   out_free;
   logic                   finish;
   logic                   bin_we;
   logic                   tot_we;
   logic [MEM_AW-1:0]      bin_waddr;
   logic [CLS_W-1:0]       tot_waddr;
   logic [CNT_W-1:0]       bin_wdata;
   logic [CNT_W-1:0]       tot_wdata;
   logic [CNT_W-1:0]       bin_rd;
   logic [CNT_W-1:0]       tot_rd;
   logic [CNT_W-1:0]       bin_inc;
   logic [CNT_W-1:0]       tot_inc;
   logic [CNT_W-1:0]       count_out;
   logic [CNT_W-1:0]       total_out;

   // unpack the request word
   assign req_func = func_type'(req_tuser[0]);
   assign class_f  = req_tdata[CLASS_W-1:0];
   assign size_f   = req_tdata[CLASS_W +: SIZE_W];
   assign sel_f    = req_tdata[CLASS_W + SIZE_W +: SEL_W];

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // configuration registers, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff  <= BINS_RESET;
         width_ff <= WIDTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_reg_type'(csr_addr))
            CSR_BINS_IN_USE: bins_ff  <= csr_wdata[BINS_CFG_W-1:0];
            CSR_BIN_WIDTH:   width_ff <= csr_wdata[WIDTH_CFG_W-1:0];
         endcase
      end
   end

   // bins in effect: zero acts as one, capped at the store size
   always_comb begin
      if (bins_ff == '0) begin
         nb = NB_W'(1);
      end else if (32'(bins_ff) > MAX_BINS) begin
         nb = NB_W'(MAX_BINS);
      end else begin
         nb = NB_W'(bins_ff);
      end
   end

   assign bin_last = BIN_W'(nb - NB_W'(1));
   assign sel_ok   = (32'(sel_f) < 32'(nb));
   // unknown classes fold onto class zero
   assign cls_fold = (32'(class_f) < MAX_CLASSES) ? CLS_W'(class_f) : '0;

   // size divided by bin width, overflow goes to the last bin
   assign div_start   = req_accept && (req_func == FUNC_RECORD);
   assign bin_clamped = (32'(quotient) >= 32'(nb)) ? bin_last : BIN_W'(quotient);

   psh_div #(
      .SIZE_BITS (SIZE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (SIZE_BITS'(size_f)),
      .divisor  (width_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_func == FUNC_RECORD) ? ST_DIVIDE : ST_READ;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_tready = 1'b0;
      clearing   = 1'b0;
      mem_rd_en  = 1'b0;
      finish     = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  clearing   = 1'b1;
         ST_IDLE:   req_tready = 1'b1;
         ST_DIVIDE: ;
         ST_READ:   mem_rd_en  = 1'b1;
         ST_UPDATE: finish     = out_free;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // clearing sweep over the bin store, class totals follow the class field
   assign clr_last = (clr_ff == MEM_AW'(MEM_DEPTH - 1));
   assign clr_in   = clearing ? clr_ff + MEM_AW'(1) : clr_ff;

   // item held while it is worked on
   always_comb begin
      func_in = func_ff;
      cls_in  = cls_ff;
      bin_in  = bin_ff;
      inr_in  = inr_ff;
      if (req_accept) begin
         func_in = req_func;
         cls_in  = cls_fold;
         bin_in  = BIN_W'(sel_f);
         inr_in  = sel_ok;
      end else if ((state_ff == ST_DIVIDE) && div_stat.done) begin
         bin_in = bin_clamped;
         inr_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      cls_ff  <= cls_in;
      bin_ff  <= bin_in;
      inr_ff  <= inr_in;
   end

   // read, saturating increment, write back
   assign bin_inc = (bin_rd == CNT_MAX) ? bin_rd : bin_rd + CNT_W'(1);
   assign tot_inc = (tot_rd == CNT_MAX) ? tot_rd : tot_rd + CNT_W'(1);

   assign bin_we    = clearing || (finish && (func_ff == FUNC_RECORD));
   assign tot_we    = bin_we;
   assign bin_waddr = clearing ? clr_ff : {cls_ff, bin_ff};
   assign tot_waddr = clearing ? clr_ff[MEM_AW-1 -: CLS_W] : cls_ff;
   assign bin_wdata = clearing ? '0 : bin_inc;
   assign tot_wdata = clearing ? '0 : tot_inc;

   psh_ram #(
      .WIDTH  (CNT_W),
      .DEPTH  (MEM_DEPTH),
      .ADDR_W (MEM_AW)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (bin_we),
      .wr_addr (bin_waddr),
      .wr_data (bin_wdata),
      .rd_en   (mem_rd_en),
      .rd_addr ({cls_ff, bin_ff}),
      .rd_data (bin_rd)
   );

   psh_ram #(
      .WIDTH  (CNT_W),
      .DEPTH  (MAX_CLASSES),
      .ADDR_W (CLS_W)
   ) u_tot_ram (
      .clock   (clock),
      .wr_en   (tot_we),
      .wr_addr (tot_waddr),
      .wr_data (tot_wdata),
      .rd_en   (mem_rd_en),
      .rd_addr (cls_ff),
      .rd_data (tot_rd)
   );

   // result values: out-of-range reads give a zero count
   always_comb begin
      if (func_ff == FUNC_RECORD) begin
         count_out = bin_inc;
         total_out = tot_inc;
      end else begin
         count_out = inr_ff ? bin_rd : '0;
         total_out = tot_rd;
      end
   end

   // output register, frees the front end while a word waits
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_bin_ff   <= BIN_IDX_W'(bin_ff);
         rsp_count_ff <= count_out;
         rsp_total_ff <= total_out;
         rsp_inr_ff   <= inr_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_total_ff, rsp_count_ff, rsp_bin_ff};
   assign rsp_tuser  = rsp_inr_ff;

   // checks
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside the update step");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during the clearing pass");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      bin_we |-> ((state_ff == ST_CLEAR) || (state_ff == ST_UPDATE)))
      else $error("store written outside clear or update");

   a_record_in_range: assert property (@(posedge clock) disable iff (reset)
      (finish && (func_ff == FUNC_RECORD)) |=> rsp_inr_ff)
      else $error("record result flagged out of range");

endmodule

/* test/per_class_size_histogram_top_tb.sv */
`timescale 1ns / 100ps

module per_class_size_histogram_top_tb;
   import psh_pkg::*;

   localparam int ITEMS_PER_PHASE = 165;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_CYCLES = 1200000;

   // one request word as the block sees it
   typedef struct {
      func_type             func;
      logic [CLASS_W-1:0]   class_id;
      logic [SIZE_W-1:0]    sample_size;
      logic [SEL_W-1:0]     bin_select;
   } sample_word_type;

   // one response word
   typedef struct {
      logic [BIN_IDX_W-1:0] bin_index;
      logic [CNT_W-1:0]     bin_count;
      logic [CNT_W-1:0]     class_total;
      logic                 in_range;
   } tally_word_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [FUNC_W-1:0]       req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [0:0]              rsp_tuser;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   // histogram mirror and register copy
   logic [CNT_W-1:0]        bin_tally [MAX_CLASSES_DEF][MAX_BINS_DEF];
   logic [CNT_W-1:0]        class_tally [MAX_CLASSES_DEF];
   logic [BINS_CFG_W-1:0]   cfg_bins  = BINS_RESET;
   logic [WIDTH_CFG_W-1:0]  cfg_width = WIDTH_RESET;

   sample_word_type         pending_words [$];
   tally_word_type          expected_tallies [$];
   sample_word_type         req_word;
   tally_word_type          seen, want;
   logic                    req_next_valid;
   int                      req_gap, rsp_gap, rsp_hold;
   int                      hold_asked = 0, hold_served = 0;
   bit                      idle_mode = 1'b1;
   int                      words_queued = 0, results_seen = 0;
   int                      n_records = 0, n_reads = 0, n_outside = 0;
   int                      csr_writes = 0, phases = 0, errors = 0;
   int                      cycle_count = 0;

   per_class_size_histogram_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // bins actually in use: zero acts as one, above the store acts as the store size
   function automatic int unsigned bins_active(input logic [BINS_CFG_W-1:0] b);
      if (b == 0) return 1;
      if (b > MAX_BINS_DEF) return MAX_BINS_DEF;
      return b;
   endfunction

   // mostly short gaps, now and then a long one; no gaps when idle_mode is off
   function automatic int idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_mode || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   // update the mirror for one accepted word and queue the response it should give
   task automatic tally_request(input sample_word_type w);
      int unsigned    nb, q;
      tally_word_type r;
      nb = bins_active(cfg_bins);
      r.in_range = 1'b1;
      // class_id is 4 bits wide, so it never needs folding onto class zero
      if (w.func == FUNC_RECORD) begin
         // zero width saturates the divider into the last bin
         if (cfg_width == 0) q = nb;
         else q = w.sample_size / cfg_width;
         if (q >= nb) q = nb - 1;
         if (bin_tally[w.class_id][q] != CNT_MAX) bin_tally[w.class_id][q]++;
         if (class_tally[w.class_id] != CNT_MAX) class_tally[w.class_id]++;
         r.bin_index = q[5:0];
         r.bin_count = bin_tally[w.class_id][q];
         n_records++;
      end else begin
         r.bin_index = w.bin_select;
         if (w.bin_select < nb) begin
            r.bin_count = bin_tally[w.class_id][w.bin_select];
         end else begin
            // bins beyond the count in use read as zero, counts kept underneath
            r.bin_count = '0;
            r.in_range  = 1'b0;
            n_outside++;
         end
         n_reads++;
      end
      r.class_total = class_tally[w.class_id];
      expected_tallies.push_back(r);
   endtask

   task automatic compare_field(input string what, input logic [CNT_W-1:0] exp_v,
                                input logic [CNT_W-1:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, act_v);
      end
   endtask

   function automatic sample_word_type mk_word(input func_type f, input logic [3:0] c,
                                               input logic [23:0] s, input logic [5:0] b);
      sample_word_type w;
      w.func        = f;
      w.class_id    = c;
      w.sample_size = s;
      w.bin_select  = b;
      return w;
   endfunction

   // random word shaped by the current register setting
   function automatic sample_word_type random_word();
      sample_word_type w;
      int unsigned     nb, span, r;
      nb = bins_active(cfg_bins);
      span = nb * cfg_width + cfg_width;
      w.func = ($urandom_range(0, 99) < 35) ? FUNC_READ : FUNC_RECORD;
      // a few busy classes so that reads find counts
      w.class_id = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      w.bin_select = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, nb - 1));
      r = $urandom_range(0, 99);
      if (r < 50) w.sample_size = (span > 24'hFFFFFF) ? 24'($urandom)
                                                      : 24'($urandom_range(0, span));
      else if (r < 70) w.sample_size = 24'($urandom_range(0, 255));
      else if (r < 90) w.sample_size = 24'($urandom);
      else w.sample_size = r[0] ? '1 : '0;
      return w;
   endfunction

   task automatic queue_word(input sample_word_type w);
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic wait_drain();
      do @(posedge clock); while (results_seen != words_queued);
   endtask

   // both registers back to back, valid held high across the pair
   task automatic write_config(input logic [15:0] bins_wd, input logic [15:0] width_wd);
      csr_valid <= 1'b1;
      csr_addr  <= CSR_BINS_IN_USE;
      csr_wdata <= bins_wd;
      do @(posedge clock); while (!csr_ready);
      cfg_bins = bins_wd[6:0];
      csr_addr  <= CSR_BIN_WIDTH;
      csr_wdata <= width_wd;
      do @(posedge clock); while (!csr_ready);
      cfg_width = width_wd;
      csr_valid <= 1'b0;
      csr_writes += 2;
   endtask

   task automatic run_phase(input logic [15:0] bins_wd, input logic [15:0] width_wd,
                            input bit gaps, input bit squeeze);
      write_config(bins_wd, width_wd);
      idle_mode = gaps;
      if (squeeze) hold_asked <= hold_asked + 1;
      repeat (ITEMS_PER_PHASE) queue_word(random_word());
      wait_drain();
      phases++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         req_next_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            tally_request(req_word);
            req_next_valid = 1'b0;
         end
         if (!req_next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_words.size() > 0) begin
               req_word = pending_words.pop_front();
               req_tdata <= {6'b0, req_word.bin_select, req_word.sample_size,
                             req_word.class_id};
               req_tuser <= req_word.func;
               req_next_valid = 1'b1;
               req_gap = idle_gap();
            end
         end
         req_tvalid <= req_next_valid;
      end
   end

   // response monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.bin_index   = rsp_tdata[5:0];
            seen.bin_count   = rsp_tdata[37:6];
            seen.class_total = rsp_tdata[69:38];
            seen.in_range    = rsp_tuser[0];
            if (expected_tallies.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none actual bin %0d count %0d total %0d",
                        $time, seen.bin_index, seen.bin_count, seen.class_total);
            end else begin
               want = expected_tallies.pop_front();
               compare_field("bin_index", want.bin_index, seen.bin_index);
               compare_field("bin_count", want.bin_count, seen.bin_count);
               compare_field("class_total", want.class_total, seen.class_total);
               compare_field("in_range", want.in_range, seen.in_range);
            end
            results_seen++;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (hold_served != hold_asked) begin
            // long hold-off so the block backs up into its input
            hold_served = hold_asked;
            rsp_hold = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ((rsp_tvalid && rsp_tready) || $urandom_range(0, 15) == 0) rsp_gap = idle_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > WATCHDOG_CYCLES) begin
         $display("per_class_size_histogram_top_tb: done, errors");
         $finish;
      end
   end

   initial begin
      for (int c = 0; c < MAX_CLASSES_DEF; c++) begin
         class_tally[c] = '0;
         for (int b = 0; b < MAX_BINS_DEF; b++) bin_tally[c][b] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset setting of 50 bins, width 100
      queue_word(mk_word(FUNC_RECORD, 4'd0, 24'd0, 6'd0));
      queue_word(mk_word(FUNC_RECORD, 4'd0, 24'd99, 6'd0));
      queue_word(mk_word(FUNC_RECORD, 4'd0, 24'd100, 6'd0));
      queue_word(mk_word(FUNC_RECORD, 4'd15, 24'hFFFFFF, 6'd63));
      queue_word(mk_word(FUNC_RECORD, 4'd15, 24'd4999, 6'd0));
      queue_word(mk_word(FUNC_RECORD, 4'd15, 24'd5000, 6'd0));
      queue_word(mk_word(FUNC_RECORD, 4'd3, 24'd4900, 6'd0));
      queue_word(mk_word(FUNC_RECORD, 4'd9, 24'd2550, 6'd63));
      queue_word(mk_word(FUNC_RECORD, 4'd5, 24'h555555, 6'h2A));
      queue_word(mk_word(FUNC_RECORD, 4'd10, 24'hAAAAAA, 6'h15));
      queue_word(mk_word(FUNC_READ, 4'd0, 24'd0, 6'd0));
      queue_word(mk_word(FUNC_READ, 4'd0, 24'hFFFFFF, 6'd1));
      queue_word(mk_word(FUNC_READ, 4'd15, 24'd0, 6'd49));
      queue_word(mk_word(FUNC_READ, 4'd15, 24'd0, 6'd50));
      queue_word(mk_word(FUNC_READ, 4'd15, 24'd0, 6'd63));
      queue_word(mk_word(FUNC_READ, 4'd7, 24'd0, 6'd5));
      queue_word(mk_word(FUNC_READ, 4'd9, 24'd0, 6'd25));
      wait_drain();
      phases++;

      // register settings, extremes first, then ordinary and random ones
      run_phase(16'd64, 16'd1, 1'b1, 1'b0);
      run_phase(16'd1, 16'd100, 1'b0, 1'b0);
      run_phase(16'd0, 16'd7, 1'b1, 1'b1);
      run_phase(16'd127, 16'hFFFF, 1'b1, 1'b0);
      // upper data bits set on the bin count write, low seven bits give 64
      run_phase(16'hA5C0, 16'd0, 1'b1, 1'b0);
      run_phase(16'd10, 16'd1000, 1'b1, 1'b0);
      run_phase(16'd33, 16'd300, 1'b0, 1'b0);
      run_phase(16'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)), 1'b1, 1'b0);
      run_phase(16'($urandom_range(1, 64)), 16'($urandom_range(1, 2000)), 1'b1, 1'b0);

      repeat (40) @(posedge clock);
      $display("covered %0d records and %0d reads (%0d beyond the bins in use)",
               n_records, n_reads, n_outside);
      $display("over %0d register settings, %0d register writes, %0d cycles",
               phases, csr_writes, cycle_count);
      if (errors == 0) begin
         $display("per_class_size_histogram_top_tb: done, clean");
      end else begin
         $display("per_class_size_histogram_top_tb: done, errors");
      end
      $finish;
   end

endmodule
